/* rtl/core/tks_pkg.sv */
// ----------------------------------------------------------------------------
// tks_pkg
// Shared widths, opcodes and the heap entry type of the top-K score table.
// ----------------------------------------------------------------------------
package tks_pkg;

    localparam int OPCODE_W = 2;
    localparam int PLAYER_W = 16;
    localparam int SCORE_W  = 31;
    localparam int RANK_W   = 6;

    // Item opcodes; the fourth code is ignored
    localparam logic [OPCODE_W-1:0] OP_INSERT  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READOUT = 2'd2;

    typedef struct packed {
        logic [PLAYER_W-1:0] player;
        logic [SCORE_W-1:0]  score;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/tks_if.sv */
// ----------------------------------------------------------------------------
// tks_if
// Valid/ready channels of the top-K score table: item input, ranked output.
// ----------------------------------------------------------------------------
interface tks_item_if;
    import tks_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PLAYER_W-1:0] player_id;
    logic [SCORE_W-1:0]  new_score;

    modport source (output valid, output opcode, output player_id, output new_score,
                    input ready);
    modport sink   (input valid, input opcode, input player_id, input new_score,
                    output ready);
endinterface

interface tks_result_if;
    import tks_pkg::*;

    logic                valid;
    logic                ready;
    logic [PLAYER_W-1:0] ranked_player;
    logic [SCORE_W-1:0]  ranked_score;
    logic [RANK_W-1:0]   rank_position;
    logic                last_of_list;

    modport source (output valid, output ranked_player, output ranked_score,
                    output rank_position, output last_of_list, input ready);
    modport sink   (input valid, input ranked_player, input ranked_score,
                    input rank_position, input last_of_list, output ready);
endinterface

/* rtl/core/tks_ram.sv */
// ----------------------------------------------------------------------------
// tks_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module tks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
    output logic [WIDTH-1:0]                         rdata_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
    output logic [WIDTH-1:0]                         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* rtl/core/top_k_score_min_heap.sv */
// ----------------------------------------------------------------------------
// top_k_score_min_heap
// Insert: a read step and a compare step, in one compare unit, for each heap level
// moved through; a full table first checks the root, dropping a score not above it.
// Readout: the heap is copied into the sort buffer, then the remaining entries are
// scanned for each rank in turn, with output stalls; an empty table returns at once.
// Clear and the unused code finish in the transfer cycle; one item at a time.
// Reset (rst_n, async, active low) empties the table; RAM contents stay.
// ----------------------------------------------------------------------------
module top_k_score_min_heap #(
    parameter int CAPACITY = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    tks_item_if.sink     item,
    tks_result_if.source result
);
    import tks_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_SU_RD, S_SU_CMP, S_RT_RD, S_RT_CMP, S_SD_RD, S_SD_CMP,
        S_CP_RD, S_CP_WR, S_SS_RD, S_SS_SCAN, S_SS_ONE, S_SS_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [AW-1:0]   i_reg, i_next;
    logic [AW-1:0]   j_reg, j_next;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    entry_t          best_reg, best_next;
    entry_t          new_reg, new_next;
    logic            first_reg, first_next;
    logic            out_valid_reg, out_valid_next;
    entry_t          out_entry_reg, out_entry_next;
    logic [RANK_W-1:0] out_rank_reg, out_rank_next;
    logic            out_last_reg, out_last_next;

    // Heap and sort-copy RAM ports
    logic            h_we, c_we;
    logic [AW-1:0]   h_waddr, h_raddr_a, h_raddr_b;
    logic [AW-1:0]   c_waddr, c_raddr_a, c_raddr_b;
    entry_t          h_wdata, h_rd_a, h_rd_b, c_wdata, c_rd_a, c_rd_b;

    logic [XW-1:0]   cnt_x, pos_x, i_x, j_x, left_x, right_x;
    logic [AW-1:0]   parent;
    logic            out_free, accept;
    entry_t          base;
    logic [AW-1:0]   base_idx;

    tks_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_heap_ram (
        .clk     (clk),
        .we      (h_we),
        .waddr   (h_waddr),
        .wdata   (h_wdata),
        .raddr_a (h_raddr_a),
        .rdata_a (h_rd_a),
        .raddr_b (h_raddr_b),
        .rdata_b (h_rd_b)
    );

    tks_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_copy_ram (
        .clk     (clk),
        .we      (c_we),
        .waddr   (c_waddr),
        .wdata   (c_wdata),
        .raddr_a (c_raddr_a),
        .rdata_a (c_rd_a),
        .raddr_b (c_raddr_b),
        .rdata_b (c_rd_b)
    );

    // Index arithmetic
    assign cnt_x   = XW'(cnt_reg);
    assign pos_x   = XW'(pos_reg);
    assign i_x     = XW'(i_reg);
    assign j_x     = XW'(j_reg);
    assign left_x  = (pos_x << 1) + XW'(1);
    assign right_x = (pos_x << 1) + XW'(2);
    assign parent  = (pos_reg - AW'(1)) >> 1;

    assign out_free     = !out_valid_reg || result.ready;
    assign accept       = item.valid && item.ready;
    assign item.ready   = (state_reg == S_IDLE);

    // Hold the output register
    assign result.valid         = out_valid_reg;
    assign result.ranked_player = out_entry_reg.player;
    assign result.ranked_score  = out_entry_reg.score;
    assign result.rank_position = out_rank_reg;
    assign result.last_of_list  = out_last_reg;

    // Running maximum seed for the selection scan
    assign base     = first_reg ? c_rd_b : best_reg;
    assign base_idx = first_reg ? i_reg : best_idx_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        new_next       = new_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_entry_next = out_entry_reg;
        out_rank_next  = out_rank_reg;
        out_last_next  = out_last_reg;
        h_we           = 1'b0;
        h_waddr        = pos_reg;
        h_wdata        = new_reg;
        h_raddr_a      = '0;
        h_raddr_b      = '0;
        c_we           = 1'b0;
        c_waddr        = i_reg;
        c_wdata        = h_rd_a;
        c_raddr_a      = i_reg;
        c_raddr_b      = i_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    new_next.player = item.player_id;
                    new_next.score  = item.new_score;
                    unique case (item.opcode)
                        OP_INSERT:
                        begin
                            if (cnt_reg < CW'(CAPACITY))
                            begin
                                pos_next   = cnt_reg[AW-1:0];
                                cnt_next   = cnt_reg + CW'(1);
                                state_next = S_SU_RD;
                            end
                            else
                            begin
                                state_next = S_RT_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        OP_READOUT:
                        begin
                            i_next = '0;
                            if (cnt_reg != '0)
                            begin
                                state_next = S_CP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Sift up: move the hole toward the root
            S_SU_RD:
            begin
                h_raddr_a = parent;
                if (pos_reg == '0)
                begin
                    h_we       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SU_CMP;
                end
            end

            S_SU_CMP:
            begin
                h_we = 1'b1;
                if (new_reg.score < h_rd_a.score)
                begin
                    h_wdata    = h_rd_a;
                    pos_next   = parent;
                    state_next = S_SU_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // Full table: replace the root only on a strictly greater score
            S_RT_RD:
            begin
                h_raddr_a  = '0;
                state_next = S_RT_CMP;
            end

            S_RT_CMP:
            begin
                pos_next   = '0;
                state_next = (new_reg.score > h_rd_a.score) ? S_SD_RD : S_IDLE;
            end

            // Sift down: fetch both children
            S_SD_RD:
            begin
                h_raddr_a = left_x[AW-1:0];
                h_raddr_b = (right_x < cnt_x) ? right_x[AW-1:0] : left_x[AW-1:0];
                if (left_x >= cnt_x)
                begin
                    h_we       = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SD_CMP;
                end
            end

            S_SD_CMP:
            begin
                h_we = 1'b1;
                if ((right_x < cnt_x) && (h_rd_b.score < h_rd_a.score)
                    && (h_rd_b.score < new_reg.score))
                begin
                    h_wdata    = h_rd_b;
                    pos_next   = right_x[AW-1:0];
                    state_next = S_SD_RD;
                end
                else if (h_rd_a.score < new_reg.score)
                begin
                    h_wdata    = h_rd_a;
                    pos_next   = left_x[AW-1:0];
                    state_next = S_SD_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            // Copy the heap into the sort buffer
            S_CP_RD:
            begin
                h_raddr_a  = i_reg;
                state_next = S_CP_WR;
            end

            S_CP_WR:
            begin
                c_we = 1'b1;
                if (i_x + XW'(1) < cnt_x)
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = S_CP_RD;
                end
                else
                begin
                    i_next     = '0;
                    state_next = S_SS_RD;
                end
            end

            // Start the scan for rank i
            S_SS_RD:
            begin
                if (i_x + XW'(1) < cnt_x)
                begin
                    c_raddr_a  = i_reg + AW'(1);
                    j_next     = i_reg + AW'(1);
                    first_next = 1'b1;
                    state_next = S_SS_SCAN;
                end
                else
                begin
                    state_next = S_SS_ONE;
                end
            end

            // Keep the first strictly greater score
            S_SS_SCAN:
            begin
                first_next = 1'b0;
                if (c_rd_a.score > base.score)
                begin
                    best_next     = c_rd_a;
                    best_idx_next = j_reg;
                end
                else
                begin
                    best_next     = base;
                    best_idx_next = base_idx;
                end
                if (j_x + XW'(1) < cnt_x)
                begin
                    j_next    = j_reg + AW'(1);
                    c_raddr_a = j_reg + AW'(1);
                end
                else
                begin
                    state_next = S_SS_EMIT;
                end
            end

            S_SS_ONE:
            begin
                best_next     = c_rd_b;
                best_idx_next = i_reg;
                state_next    = S_SS_EMIT;
            end

            // Transfer rank i and swap the displaced entry into the gap
            S_SS_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_entry_next = best_reg;
                    out_rank_next  = RANK_W'(i_reg);
                    out_last_next  = (i_x + XW'(1) == cnt_x);
                    c_we           = (best_idx_reg != i_reg);
                    c_waddr        = best_idx_reg;
                    c_wdata        = c_rd_b;
                    if (i_x + XW'(1) < cnt_x)
                    begin
                        i_next     = i_reg + AW'(1);
                        state_next = S_SS_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        new_reg       <= new_next;
        out_entry_reg <= out_entry_next;
        out_rank_reg  <= out_rank_next;
        out_last_reg  <= out_last_next;
    end

`ifndef ASSERT_OFF
    // Entry count never exceeds capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // Heap writes stay inside the held part
    a_heap_wr: assert property (@(posedge clk) disable iff (!rst_n)
        h_we |-> (XW'(h_waddr) < cnt_x))
        else $error("heap write outside held entries");

    // Sort buffer writes stay inside the copied part
    a_copy_wr: assert property (@(posedge clk) disable iff (!rst_n)
        c_we |-> (XW'(c_waddr) < cnt_x))
        else $error("sort buffer write outside copied entries");

    // A clear transfer empties the table
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.opcode == OP_CLEAR)) |=> (cnt_reg == '0))
        else $error("clear did not empty the table");

    // A new result is loaded only from the emit step
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && !(out_valid_reg && !result.ready))
            |-> (state_reg == S_SS_EMIT))
        else $error("result loaded outside emit step");
`endif

endmodule

/* tb/tks_heap_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tks_heap_checker
// Watches the item and ranked-result channels of the top-K score table. It
// keeps its own min-heap of the best scores and queues the ranked list that
// each readout should produce. Each result transfer is compared field by field
// with the oldest queued entry.
// ----------------------------------------------------------------------------
module tks_heap_checker #(
    parameter int CAPACITY = 10
) (
    input  logic  clk,
    input  logic  rst_n,
    tks_item_if   item_mon,
    tks_result_if result_mon,
    output int    mismatches,
    output int    awaited
);
    import tks_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic [PLAYER_W-1:0] player;
        logic [SCORE_W-1:0]  score;
        logic [RANK_W-1:0]   rank;
        logic                is_last;
    } ranked_t;

    entry_t  kept [CAPACITY];
    int      kept_count = 0;
    ranked_t ranked_q [$];
    int      fail_total = 0;
    int      queue_depth = 0;

    assign mismatches = fail_total;
    assign awaited    = queue_depth;

    function automatic void swap_kept(int a, int b);
        entry_t t;
        t       = kept[a];
        kept[a] = kept[b];
        kept[b] = t;
    endfunction

    // Move a new entry toward the root while strictly below its parent
    function automatic void bubble_up(int pos);
        int parent;
        bit done;
        done = 1'b0;
        while (!done && pos > 0)
        begin
            parent = (pos - 1) / 2;
            if (kept[pos].score >= kept[parent].score)
                done = 1'b1;
            else
            begin
                swap_kept(pos, parent);
                pos = parent;
            end
        end
    endfunction

    // Move a replaced root down toward the smaller child
    function automatic void push_down(int pos);
        int l;
        int r;
        int low;
        bit done;
        done = 1'b0;
        while (!done && pos < kept_count)
        begin
            l   = 2 * pos + 1;
            r   = 2 * pos + 2;
            low = pos;
            if (l < kept_count && kept[l].score < kept[low].score)
                low = l;
            if (r < kept_count && kept[r].score < kept[low].score)
                low = r;
            if (low == pos)
                done = 1'b1;
            else
            begin
                swap_kept(pos, low);
                pos = low;
            end
        end
    endfunction

    // Order a copy of the heap by selection for the maximum, then queue it
    function automatic void rank_kept();
        entry_t  order [CAPACITY];
        entry_t  t;
        ranked_t want;
        int      best;
        for (int i = 0; i < kept_count; i++)
            order[i] = kept[i];
        for (int i = 0; i + 1 < kept_count; i++)
        begin
            best = i;
            for (int j = i + 1; j < kept_count; j++)
                if (order[j].score > order[best].score)
                    best = j;
            if (best != i)
            begin
                t           = order[i];
                order[i]    = order[best];
                order[best] = t;
            end
        end
        for (int i = 0; i < kept_count; i++)
        begin
            want.player  = order[i].player;
            want.score   = order[i].score;
            want.rank    = i[RANK_W-1:0];
            want.is_last = (i + 1 == kept_count);
            ranked_q.push_back(want);
        end
    endfunction

    function automatic void absorb_item(logic [OPCODE_W-1:0] op,
                                        logic [PLAYER_W-1:0] pid,
                                        logic [SCORE_W-1:0]  sc);
        case (op)
            OP_INSERT:
            begin
                if (kept_count < CAPACITY)
                begin
                    kept[kept_count].player = pid;
                    kept[kept_count].score  = sc;
                    bubble_up(kept_count);
                    kept_count++;
                end
                else if (sc > kept[0].score)
                begin
                    kept[0].player = pid;
                    kept[0].score  = sc;
                    push_down(0);
                end
            end
            OP_CLEAR:   kept_count = 0;
            OP_READOUT: rank_kept();
            default:    ;
        endcase
    endfunction

    function automatic void check_result();
        ranked_t want;
        if (ranked_q.size() == 0)
        begin
            fail_total++;
            if (fail_total <= MAX_REPORTS)
                $display("%0t: unexpected ranked result: player %h score %h rank %0d last %b",
                         $time, result_mon.ranked_player, result_mon.ranked_score,
                         result_mon.rank_position, result_mon.last_of_list);
        end
        else
        begin
            want = ranked_q.pop_front();
            if (result_mon.ranked_player !== want.player ||
                result_mon.ranked_score  !== want.score  ||
                result_mon.rank_position !== want.rank   ||
                result_mon.last_of_list  !== want.is_last)
            begin
                fail_total++;
                if (fail_total <= MAX_REPORTS)
                begin
                    $display("%0t: ranked result mismatch", $time);
                    $display("    expected player %h score %h rank %0d last %b",
                             want.player, want.score, want.rank, want.is_last);
                    $display("    actual   player %h score %h rank %0d last %b",
                             result_mon.ranked_player, result_mon.ranked_score,
                             result_mon.rank_position, result_mon.last_of_list);
                end
            end
        end
    endfunction

    // Check result transfers first, then fold in the item transfer of this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_count = 0;
            ranked_q.delete();
            queue_depth = 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
                check_result();
            if (item_mon.valid && item_mon.ready)
                absorb_item(item_mon.opcode, item_mon.player_id, item_mon.new_score);
            queue_depth = ranked_q.size();
        end
    end

endmodule

/* tb/tb_top_k_score_min_heap.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top_k_score_min_heap
// Drives insert, clear, readout and unused items into the top-K score table,
// first a directed list of edge cases and then a random mix, with random
// gaps on both channels and one long receiver hold-off. The checker beside
// the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top_k_score_min_heap;
    import tks_pkg::*;

    localparam int HEAP_DEPTH   = 10;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 110;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 200;
    localparam int TIMEOUT_NS   = 5_000_000;

    localparam logic [OPCODE_W-1:0] OP_UNUSED  = 2'd3;
    localparam logic [SCORE_W-1:0]  SCORE_TOP  = '1;
    localparam logic [PLAYER_W-1:0] PLAYER_TOP = '1;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   awaited;
    int   tx_calm = 0;
    int   rx_calm = 0;
    bit   hold_req = 1'b0;

    tks_item_if   item_ch ();
    tks_result_if result_ch ();

    top_k_score_min_heap #(
        .CAPACITY (HEAP_DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    tks_heap_checker #(
        .CAPACITY (HEAP_DEPTH)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_mon   (item_ch),
        .result_mon (result_ch),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int draw_gap();
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        return gap;
    endfunction

    // Small scores for ties, scores near the top, or anything at all
    function automatic logic [SCORE_W-1:0] draw_score();
        int                 roll;
        logic [SCORE_W-1:0] sc;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            sc = SCORE_W'($urandom_range(0, 15));
        else if (roll < 55)
            sc = SCORE_W'(SCORE_TOP - $urandom_range(0, 7));
        else
            sc = SCORE_W'($urandom);
        return sc;
    endfunction

    function automatic logic [OPCODE_W-1:0] draw_opcode();
        int                  roll;
        logic [OPCODE_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 72)
            op = OP_INSERT;
        else if (roll < 88)
            op = OP_READOUT;
        else if (roll < 94)
            op = OP_CLEAR;
        else
            op = OP_UNUSED;
        return op;
    endfunction

    // Offer one item after a random gap and hold it until the transfer
    task automatic send_item(input logic [OPCODE_W-1:0] op,
                             input logic [PLAYER_W-1:0] pid,
                             input logic [SCORE_W-1:0]  sc);
        int gap;
        if (tx_calm > 0)
        begin
            tx_calm--;
            gap = 0;
        end
        else
        begin
            gap = draw_gap();
            if ($urandom_range(0, 19) == 0)
                tx_calm = 12;
        end
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.opcode    <= op;
        item_ch.player_id <= pid;
        item_ch.new_score <= sc;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stalls, calm stretches, and one long hold-off on request
    initial
    begin
        int stall_left;
        int gap;
        stall_left      = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (hold_req)
            begin
                hold_req         = 1'b0;
                stall_left       = LONG_HOLD - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_calm > 0)
                begin
                    rx_calm--;
                    gap = 0;
                end
                else
                begin
                    gap = draw_gap();
                    if ($urandom_range(0, 49) == 0)
                        rx_calm = 30;
                end
                if (gap > 0)
                begin
                    stall_left       = gap - 1;
                    result_ch.ready <= 1'b0;
                end
                else
                    result_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [OPCODE_W-1:0] op;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.opcode    = OP_INSERT;
        item_ch.player_id = '0;
        item_ch.new_score = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty readout, unused opcode, field extremes and a tie on sift-up
        send_item(OP_READOUT, 16'h0000, '0);
        send_item(OP_UNUSED,  PLAYER_TOP, SCORE_TOP);
        send_item(OP_INSERT,  PLAYER_TOP, SCORE_TOP);
        send_item(OP_INSERT,  16'h0000, '0);
        send_item(OP_INSERT,  16'h1234, '0);
        send_item(OP_READOUT, 16'h0000, '0);

        // Fill to capacity with duplicate scores
        send_item(OP_INSERT, 16'h0101, 31'd500);
        send_item(OP_INSERT, 16'h0202, 31'd500);
        send_item(OP_INSERT, 16'h0303, 31'd1);
        send_item(OP_INSERT, 16'h0404, SCORE_TOP);
        send_item(OP_INSERT, 16'h0505, 31'd250);
        send_item(OP_INSERT, 16'h0606, 31'd250);
        send_item(OP_INSERT, 16'h0707, 31'd100);

        // Full heap: tie with the root is dropped, a larger score replaces it
        send_item(OP_INSERT,  16'h0808, '0);
        send_item(OP_INSERT,  16'h0909, 31'd1);
        send_item(OP_INSERT,  16'hAAAA, SCORE_TOP - 31'd1);
        send_item(OP_READOUT, 16'h0000, '0);

        // Clear, empty readout, then a single-entry list
        send_item(OP_CLEAR,   PLAYER_TOP, SCORE_TOP);
        send_item(OP_READOUT, 16'h0000, '0);
        send_item(OP_INSERT,  16'h5555, 31'h2AAA_AAAA);
        send_item(OP_READOUT, 16'h0000, '0);

        // Random mix; open with a readout under a long receiver hold-off
        hold_req = 1'b1;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            op = (k == 0) ? OP_READOUT : draw_opcode();
            send_item(op, PLAYER_W'($urandom_range(0, 65535)), draw_score());
        end
        item_ch.valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (awaited != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && awaited == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
